// ===== hdl/rcd_pkg.sv =====
package rcd_pkg;

    localparam int COUNT_W   = 24;
    localparam int BLOCK_MAX = 32;
    localparam int RES_CAP   = 64;
    localparam int CNT_W     = $clog2(RES_CAP + 1);
    localparam int CODE_W    = 5;
    localparam int RAW_W     = 32;
    localparam int HDR_BYTES = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0] CODE_ZERO = 5'd0;
    localparam logic [CODE_W-1:0] CODE_RAW  = 5'd27;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;

    localparam logic [2:0] ST_RUNNING   = 3'd0;
    localparam logic [2:0] ST_DONE      = 3'd1;
    localparam logic [2:0] ST_OVERRUN   = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_TRAILING  = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CODE,
        PH_UNARY,
        PH_LOW,
        PH_RAW,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_ZREP,
        S_EMIT,
        S_END
    } t_step;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic [31:0] pixel;
        logic        pixel_valid;
        logic        run_last;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic [COUNT_W-1:0] pixel_count;
        logic [5:0]         block_size;
    } t_cfg;

    function automatic logic [31:0] low_mask(input logic [5:0] w);
        logic [31:0] m;
        if (w >= 6'd32) begin
            m = '1;
        end else begin
            m = ~(32'hFFFF_FFFF << w[4:0]);
        end
        return m;
    endfunction

    function automatic logic [31:0] unzigzag(input logic [31:0] d);
        logic [31:0] h;
        h = d >> 1;
        return d[0] ? ~h : h;
    endfunction

    function automatic logic [5:0] block_len(input logic [COUNT_W-1:0] count,
                                             input logic [COUNT_W-1:0] done,
                                             input logic [5:0] bs);
        logic [5:0]         be;
        logic [COUNT_W-1:0] left;
        if (bs == 6'd0) begin
            be = 6'd1;
        end else if (bs > 6'(BLOCK_MAX)) begin
            be = 6'(BLOCK_MAX);
        end else begin
            be = bs;
        end
        left = count - done;
        return (left < COUNT_W'(be)) ? left[5:0] : be;
    endfunction

endpackage

// ===== hdl/rcd_if.sv =====
interface rcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;
    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface rcd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel;
    logic        pixel_valid;
    logic        run_last;
    logic [2:0]  status;
    modport source (output valid, output pixel, output pixel_valid, output run_last,
                    output status, input ready);
    modport sink (input valid, input pixel, input pixel_valid, input run_last,
                  input status, output ready);
endinterface

interface rcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rcd_front.sv =====
module rcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rcd_in_if.sink           i_in,
    rcd_cfg_if.sink          i_cfg,
    input  logic             i_pop,
    output logic             o_beat_valid,
    output rcd_pkg::t_beat   o_beat,
    output rcd_pkg::t_cfg    o_cfg
);
    import rcd_pkg::*;

    t_beat      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    t_cfg       r_cfg;
    logic       w_push;

    assign i_in.ready   = (r_fill != 2'd2);
    assign i_cfg.ready  = 1'b1;
    assign w_push       = i_in.valid && i_in.ready;
    assign o_beat_valid = (r_fill != 2'd0);
    assign o_beat       = r_mem[r_rp];
    assign o_cfg        = r_cfg;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{in_byte: i_in.in_byte, last_byte: i_in.last_byte};
        end
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
            r_cfg  <= '{pixel_count: COUNT_W'(1), block_size: 6'(BLOCK_MAX)};
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(i_pop);
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_PIXEL_COUNT: r_cfg.pixel_count <= i_cfg.data[COUNT_W-1:0];
                    REG_BLOCK_SIZE:  r_cfg.block_size  <= i_cfg.data[5:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== hdl/rcd_back.sv =====
module rcd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat_valid,
    input  rcd_pkg::t_beat    i_beat,
    output logic              o_pop,
    input  rcd_pkg::t_cfg     i_cfg,
    output logic              o_res_valid,
    output rcd_pkg::t_result  o_res,
    input  logic              i_res_free
);
    import rcd_pkg::*;

    t_phase             r_ph, n_ph;
    t_step              r_step, n_step;
    logic [31:0]        r_buf, n_buf;
    logic [5:0]         r_npend, n_npend;
    logic [31:0]        r_prev, n_prev;
    logic [2:0]         r_hdr, n_hdr;
    logic [COUNT_W-1:0] r_done, n_done;
    logic [5:0]         r_brem, n_brem;
    logic [4:0]         r_k, n_k;
    logic [31:0]        r_ucnt, n_ucnt;
    logic [39:0]        r_acc, n_acc;
    logic [5:0]         r_n, n_n;
    logic               r_last, n_last;
    logic               r_fin, n_fin;
    logic               r_halt, n_halt;
    logic               r_isrun, n_isrun;
    logic [5:0]         r_zrep, n_zrep;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_pv, n_pv;
    logic [31:0]        r_ppix, n_ppix;
    logic [31:0]        r_diff, n_diff;

    logic        w_push_ok, w_push;
    logic [31:0] w_push_pix;
    logic [5:0]  w_width, w_shamt, w_bl;
    logic [31:0] w_field;
    logic [4:0]  w_code;
    logic [2:0]  w_status;
    logic        w_need;

    assign w_push_ok = (r_cnt == CNT_W'(RES_CAP)) || !r_pv || i_res_free;
    assign w_bl      = block_len(i_cfg.pixel_count, r_done, i_cfg.block_size);

    always_comb begin
        unique case (r_ph)
            PH_CODE:  w_width = 6'(CODE_W);
            PH_LOW:   w_width = {1'b0, r_k};
            PH_RAW:   w_width = 6'(RAW_W);
            default:  w_width = 6'd1;
        endcase
    end

    assign w_shamt = r_n - w_width;
    assign w_field = 32'(r_acc >> w_shamt) & low_mask(w_width);
    assign w_code  = w_field[4:0];

    always_comb begin
        n_ph = r_ph; n_step = r_step; n_buf = r_buf; n_npend = r_npend;
        n_prev = r_prev; n_hdr = r_hdr; n_done = r_done; n_brem = r_brem;
        n_k = r_k; n_ucnt = r_ucnt; n_acc = r_acc; n_n = r_n; n_last = r_last;
        n_fin = r_fin; n_halt = r_halt; n_isrun = r_isrun; n_zrep = r_zrep;
        n_cnt = r_cnt; n_pv = r_pv; n_ppix = r_ppix; n_diff = r_diff;
        o_pop = 1'b0; o_res_valid = 1'b0; o_res = '0;
        w_push = 1'b0; w_push_pix = r_prev;
        w_status = ST_RUNNING; w_need = 1'b0;

        unique case (r_step)
            S_IDLE: begin
                if (i_beat_valid) begin
                    o_pop = 1'b1;
                    n_last = i_beat.last_byte;
                    n_fin = 1'b0; n_halt = 1'b0; n_isrun = 1'b0;
                    n_cnt = '0; n_pv = 1'b0;
                    n_step = S_END;
                    if (r_ph == PH_HALT) begin
                        n_halt = 1'b1;
                        n_fin  = 1'b1;
                    end else if (r_ph == PH_HEADER) begin
                        n_prev = {r_prev[23:0], i_beat.in_byte};
                        n_hdr  = r_hdr + 3'd1;
                        if (n_hdr >= 3'(HDR_BYTES)) begin
                            n_ph = PH_CODE; n_buf = '0; n_npend = '0;
                            n_fin = (r_done == i_cfg.pixel_count);
                        end
                    end else begin
                        n_acc = {r_buf, i_beat.in_byte};
                        n_n = r_npend + 6'd8;
                        n_isrun = 1'b1;
                        n_step = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_fin) begin
                    n_step = S_END;
                end else begin
                    unique case (r_ph)
                        PH_CODE: begin
                            if (r_n < w_width) begin
                                n_step = S_END;
                            end else begin
                                n_n = w_shamt;
                                n_fin = (r_done == i_cfg.pixel_count);
                                if (w_code == CODE_ZERO) begin
                                    if (w_bl != 6'd0) begin
                                        n_zrep = w_bl; n_fin = 1'b0; n_step = S_ZREP;
                                    end
                                end else if (w_code < CODE_RAW) begin
                                    n_k = w_code - 5'd1; n_brem = w_bl;
                                    n_ucnt = '0; n_ph = PH_UNARY;
                                end else if (w_code == CODE_RAW) begin
                                    n_brem = w_bl; n_ph = PH_RAW;
                                end
                            end
                        end
                        PH_UNARY: begin
                            if (r_n == 6'd0) begin
                                n_step = S_END;
                            end else begin
                                n_n = w_shamt;
                                if (w_field[0]) n_ph = PH_LOW;
                                else n_ucnt = r_ucnt + 32'd1;
                            end
                        end
                        PH_LOW, PH_RAW: begin
                            if (r_n < w_width) begin
                                n_step = S_END;
                            end else begin
                                n_n = w_shamt;
                                n_brem = r_brem - 6'd1;
                                if (r_ph == PH_LOW) begin
                                    n_diff = (r_ucnt << r_k) + w_field;
                                    n_ucnt = '0;
                                    n_ph = (n_brem != 6'd0) ? PH_UNARY : PH_CODE;
                                end else begin
                                    n_diff = w_field;
                                    n_ph = (n_brem != 6'd0) ? PH_RAW : PH_CODE;
                                end
                                n_step = S_EMIT;
                            end
                        end
                        default: n_step = S_END;
                    endcase
                end
            end
            S_ZREP: begin
                if (w_push_ok) begin
                    w_push = 1'b1; w_push_pix = r_prev;
                    n_done = r_done + COUNT_W'(1);
                    n_zrep = r_zrep - 6'd1;
                    if (r_zrep == 6'd1) begin
                        n_step = S_RUN;
                        n_fin = (n_done == i_cfg.pixel_count);
                    end
                end
            end
            S_EMIT: begin
                if (w_push_ok) begin
                    w_push_pix = r_prev + unzigzag(r_diff);
                    w_push = 1'b1;
                    n_prev = w_push_pix;
                    n_done = r_done + COUNT_W'(1);
                    n_fin = (n_done == i_cfg.pixel_count);
                    n_step = S_RUN;
                end
            end
            S_END: begin
                if (r_halt) w_status = ST_OVERRUN;
                else if (r_fin) w_status = r_last ? ST_DONE : ST_TRAILING;
                else if (r_last) w_status = ST_TRUNCATED;
                w_need = r_pv || (w_status != ST_RUNNING);
                if (!w_need || i_res_free) begin
                    o_res_valid = w_need;
                    o_res = '{pixel: r_pv ? r_ppix : 32'd0, pixel_valid: r_pv,
                              run_last: 1'b1, status: w_status};
                    n_pv = 1'b0;
                    if (r_isrun) begin
                        n_npend = r_n;
                        n_buf = r_acc[31:0] & low_mask(r_n);
                    end
                    if (r_fin && !r_last) begin
                        n_ph = PH_HALT;
                    end else if (r_last) begin
                        n_buf = '0; n_npend = '0; n_prev = '0; n_hdr = '0;
                        n_done = '0; n_brem = '0; n_k = '0; n_ucnt = '0;
                        n_ph = PH_HEADER;
                    end
                    n_step = S_IDLE;
                end
            end
            default: n_step = S_IDLE;
        endcase

        // Hold the newest pixel back so the byte's final beat can carry status.
        if (w_push && (r_cnt != CNT_W'(RES_CAP))) begin
            if (r_pv) begin
                o_res_valid = 1'b1;
                o_res = '{pixel: r_ppix, pixel_valid: 1'b1, run_last: 1'b0,
                          status: ST_RUNNING};
            end
            n_pv = 1'b1;
            n_ppix = w_push_pix;
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_n <= n_n; r_zrep <= n_zrep;
        r_ppix <= n_ppix; r_diff <= n_diff; r_last <= n_last;
        r_isrun <= n_isrun; r_halt <= n_halt;
        if (!i_rst_n) begin
            r_ph <= PH_HEADER; r_step <= S_IDLE; r_buf <= '0; r_npend <= '0;
            r_prev <= '0; r_hdr <= '0; r_done <= '0; r_brem <= '0; r_k <= '0;
            r_ucnt <= '0; r_fin <= 1'b0; r_cnt <= '0; r_pv <= 1'b0;
        end else begin
            r_ph <= n_ph; r_step <= n_step; r_buf <= n_buf; r_npend <= n_npend;
            r_prev <= n_prev; r_hdr <= n_hdr; r_done <= n_done; r_brem <= n_brem;
            r_k <= n_k; r_ucnt <= n_ucnt; r_fin <= n_fin; r_cnt <= n_cnt;
            r_pv <= n_pv;
        end
    end
endmodule

// ===== hdl/rcd_out.sv =====
module rcd_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  rcd_pkg::t_result  i_res,
    output logic              o_free,
    rcd_out_if.source         o_out
);
    import rcd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free            = !r_valid || o_out.ready;
    assign o_out.valid       = r_valid;
    assign o_out.pixel       = r_res.pixel;
    assign o_out.pixel_valid = r_res.pixel_valid;
    assign o_out.run_last    = r_res.run_last;
    assign o_out.status      = r_res.status;

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_free) begin
            r_res <= i_res;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end
endmodule

// ===== hdl/rice_decoder_32bit_unit.sv =====
// Rice decoder for 32-bit pixels, one compressed byte per input beat.
// A header byte goes from the idle step to the end step; a stream byte goes through run
// steps (codes, unary bits, low/raw fields), emit or zero-run steps, then the end step.
// Throughput: the single-step decode engine gives one bit-field or pixel per cycle; pixels wait on a full output.
// A two-beat queue lets bytes be taken while the engine or the output is busy.
// Reset (synchronous, active low) clears the stream state; pixel_count is 1, block_size 32.
module rice_decoder_32bit_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rcd_in_if.sink     i_in,
    rcd_cfg_if.sink    i_cfg,
    rcd_out_if.source  o_out
);
    import rcd_pkg::*;

    logic    w_pop, w_beat_valid, w_res_valid, w_free;
    t_beat   w_beat;
    t_cfg    w_cfg;
    t_result w_res;

    rcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_pop        (w_pop),
        .o_beat_valid (w_beat_valid),
        .o_beat       (w_beat),
        .o_cfg        (w_cfg)
    );

    rcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (w_beat_valid),
        .i_beat       (w_beat),
        .o_pop        (w_pop),
        .i_cfg        (w_cfg),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .i_res_free   (w_free)
    );

    rcd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_free),
        .o_out       (o_out)
    );
endmodule
